/* rtl/core/adaptive_threshold_stim_trigger_assert.svh */
// Assertion macros for the threshold trigger block.
`ifndef ADAPTIVE_THRESHOLD_STIM_TRIGGER_ASSERT_SVH
`define ADAPTIVE_THRESHOLD_STIM_TRIGGER_ASSERT_SVH

`ifndef SYNTH

`define ATST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ATST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ATST_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define ATST_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/atst_pkg.sv */
package atst_pkg;

  localparam int unsigned WIN_DEF   = 64;
  localparam int unsigned NINIT_DEF = 1024;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] FRAC_RESET = 16'hC000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAC = 2'd0,
    CFG_AMP  = 2'd1,
    CFG_PW   = 2'd2,
    CFG_FREQ = 2'd3
  } cfg_idx_t;

endpackage

/* rtl/core/adaptive_threshold_stim_trigger.sv */
// Adaptive threshold stimulation trigger.
// The input channel takes one signed band-filtered sample per request
// (in_valid, in_stall, in_filtered_sample). The output channel returns one
// result request per sample (out_valid, out_stall and the out_ fields).
// The block rectifies the sample, updates a WIN-entry sliding window and
// computes the window mean on one shared multiplier (reciprocal multiply,
// then one correction step). A normal sample runs through the sum, multiply,
// quotient, multiply, correction, decision and output states in that order.
// The first NINIT means fill the calibration memory. The sample that fills it
// also runs a bitwise rank search over that memory: rank and key setup, then
// 16 passes, each a read of all NINIT entries, one per cycle, and a tail step.
// in_stall stays high while a sample is being processed.
// A finished result sits in the output register until taken; the next sample
// is accepted meanwhile and waits at its last step only if the held result is stalled.
// Synchronous reset clears the window, sum, calibration count and threshold and
// restores the register defaults; no clearing pass is needed.
// Configuration writes are taken at any time and apply to a sample in flight too.
`include "adaptive_threshold_stim_trigger_assert.svh"

module adaptive_threshold_stim_trigger #(
  parameter int unsigned WIN   = atst_pkg::WIN_DEF,
  parameter int unsigned NINIT = atst_pkg::NINIT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [atst_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [atst_pkg::DATA_W-1:0]            cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [atst_pkg::DATA_W-1:0]     in_filtered_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [atst_pkg::DATA_W-1:0]            out_mean_amplitude,
  output logic                                   out_calibrating,
  output logic                                   out_threshold_ready,
  output logic [atst_pkg::DATA_W-1:0]            out_threshold_level,
  output logic                                   out_stimulate,
  output logic [atst_pkg::DATA_W-1:0]            out_out_amplitude,
  output logic [atst_pkg::DATA_W-1:0]            out_out_pulse_width,
  output logic [atst_pkg::DATA_W-1:0]            out_out_frequency
);

  localparam int unsigned DW    = atst_pkg::DATA_W;
  localparam int unsigned SUMW  = $clog2(WIN * 32768 + 1);
  localparam int unsigned PW    = $clog2(WIN);
  localparam int unsigned IW    = (NINIT > 1) ? $clog2(NINIT) : 1;
  localparam int unsigned CW    = $clog2(NINIT + 1);
  localparam int unsigned BW    = $clog2(DW);
  localparam int unsigned RECIP = (2 ** SUMW) / WIN;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_MUL1, S_QUO, S_MUL2, S_CORR, S_DECIDE,
    S_RANK, S_KSET, S_SCAN, S_TAIL, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [DW-1:0]       mag_r, mag_nxt;
  logic [SUMW-1:0]     sum_r, sum_nxt;
  logic [PW-1:0]       ptr_r, ptr_nxt;
  logic                wrap_r, wrap_nxt;
  logic [DW-1:0]       q_r, q_nxt;
  logic [2*SUMW-1:0]   prod_r;
  logic [DW-1:0]       mean_r, mean_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                cal_r, cal_nxt;
  logic [DW-1:0]       thr_r, thr_nxt;
  logic                stim_r, stim_nxt;
  logic                rdy_r, rdy_nxt;
  logic                was_cal_r, was_cal_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [DW-1:0]       pre_r, pre_nxt;
  logic [BW-1:0]       bit_r, bit_nxt;
  logic [IW-1:0]       sidx_r, sidx_nxt;
  logic [CW-1:0]       scnt_r, scnt_nxt;
  logic                rdv_r, rdv_nxt;
  logic [DW-1:0]       frac_r, frac_nxt;
  logic [DW-1:0]       amp_r, amp_nxt;
  logic [DW-1:0]       pw_r, pw_nxt;
  logic [DW-1:0]       freq_r, freq_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DW-1:0]       o_mean_r, o_mean_nxt;
  logic                o_cal_r, o_cal_nxt;
  logic                o_rdy_r, o_rdy_nxt;
  logic [DW-1:0]       o_thr_r, o_thr_nxt;
  logic                o_stim_r, o_stim_nxt;
  logic [DW-1:0]       o_amp_r, o_amp_nxt;
  logic [DW-1:0]       o_pw_r, o_pw_nxt;
  logic [DW-1:0]       o_freq_r, o_freq_nxt;

  logic [DW-1:0]       win_mem [WIN];
  logic [DW-1:0]       win_rd_r;
  logic                win_we;
  logic [DW-1:0]       cal_mem [NINIT];
  logic [DW-1:0]       cal_rd_r;
  logic                cal_we;

  logic [SUMW-1:0]     mul_a, mul_b;
  logic [DW-1:0]       in_mag;
  logic [DW-1:0]       old_mag;
  logic [SUMW-1:0]     rem;
  logic [DW-1:0]       scan_mask;
  logic                scan_hit;
  logic [CW-1:0]       scnt_fin;
  logic [CW-1:0]       k_raw;
  logic [DW-1:0]       pre_fin;

  assign in_mag    = in_filtered_sample[DW-1] ? DW'(~in_filtered_sample + 1'b1)
                                             : in_filtered_sample;
  assign old_mag   = wrap_r ? win_rd_r : '0;
  assign rem       = sum_r - prod_r[SUMW-1:0];
  assign scan_mask = {DW{1'b1}} << bit_r;
  assign scan_hit  = rdv_r && ((cal_rd_r & scan_mask) == pre_r);
  assign scnt_fin  = scnt_r + CW'(scan_hit);
  assign k_raw     = prod_r[DW +: CW];
  assign win_we    = (state_r == S_SUM);
  assign cal_we    = (state_r == S_DECIDE) && cal_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL1: begin
        mul_a = sum_r;
        mul_b = SUMW'(RECIP);
      end
      S_MUL2: begin
        mul_a = SUMW'(q_r);
        mul_b = SUMW'(WIN);
      end
      S_RANK: begin
        mul_a = SUMW'(NINIT);
        mul_b = SUMW'(frac_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    sum_nxt       = sum_r;
    ptr_nxt       = ptr_r;
    wrap_nxt      = wrap_r;
    q_nxt         = q_r;
    mean_nxt      = mean_r;
    cnt_nxt       = cnt_r;
    cal_nxt       = cal_r;
    thr_nxt       = thr_r;
    stim_nxt      = stim_r;
    rdy_nxt       = rdy_r;
    was_cal_nxt   = was_cal_r;
    k_nxt         = k_r;
    pre_nxt       = pre_r;
    bit_nxt       = bit_r;
    sidx_nxt      = sidx_r;
    scnt_nxt      = scnt_r;
    rdv_nxt       = (state_r == S_SCAN);
    frac_nxt      = frac_r;
    amp_nxt       = amp_r;
    pw_nxt        = pw_r;
    freq_nxt      = freq_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_mean_nxt    = o_mean_r;
    o_cal_nxt     = o_cal_r;
    o_rdy_nxt     = o_rdy_r;
    o_thr_nxt     = o_thr_r;
    o_stim_nxt    = o_stim_r;
    o_amp_nxt     = o_amp_r;
    o_pw_nxt      = o_pw_r;
    o_freq_nxt    = o_freq_r;
    pre_fin       = pre_r;

    if (cfg_we) begin
      unique case (atst_pkg::cfg_idx_t'(cfg_index))
        atst_pkg::CFG_FRAC: frac_nxt = cfg_wdata;
        atst_pkg::CFG_AMP:  amp_nxt  = cfg_wdata;
        atst_pkg::CFG_PW:   pw_nxt   = cfg_wdata;
        atst_pkg::CFG_FREQ: freq_nxt = cfg_wdata;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt   = in_mag;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt = sum_r - SUMW'(old_mag) + SUMW'(mag_r);
        if (ptr_r == PW'(WIN - 1)) begin
          ptr_nxt  = '0;
          wrap_nxt = 1'b1;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        state_nxt = S_QUO;
      end
      S_QUO: begin
        q_nxt     = prod_r[SUMW +: DW];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        state_nxt = S_CORR;
      end
      S_CORR: begin
        mean_nxt  = (rem >= SUMW'(WIN)) ? q_r + 1'b1 : q_r;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        was_cal_nxt = cal_r;
        rdy_nxt     = 1'b0;
        stim_nxt    = 1'b0;
        state_nxt   = S_OUT;
        if (cal_r) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(NINIT - 1)) begin
            state_nxt = S_RANK;
          end
        end else begin
          stim_nxt = mean_r > thr_r;
        end
      end
      S_RANK: begin
        state_nxt = S_KSET;
      end
      S_KSET: begin
        k_nxt     = (k_raw > CW'(NINIT - 1)) ? CW'(NINIT - 1) : k_raw;
        pre_nxt   = '0;
        bit_nxt   = BW'(DW - 1);
        sidx_nxt  = '0;
        scnt_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        scnt_nxt = scnt_fin;
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == IW'(NINIT - 1)) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        if (k_r >= scnt_fin) begin
          pre_fin = pre_r | (DW'(1) << bit_r);
          k_nxt   = k_r - scnt_fin;
        end
        pre_nxt  = pre_fin;
        sidx_nxt = '0;
        scnt_nxt = '0;
        if (bit_r == '0) begin
          thr_nxt   = pre_fin;
          cal_nxt   = 1'b0;
          rdy_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_mean_nxt    = mean_r;
          o_cal_nxt     = was_cal_r;
          o_rdy_nxt     = rdy_r;
          o_thr_nxt     = thr_r;
          o_stim_nxt    = stim_r;
          o_amp_nxt     = stim_r ? amp_r  : '0;
          o_pw_nxt      = stim_r ? pw_r   : '0;
          o_freq_nxt    = stim_r ? freq_r : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    q_r       <= q_nxt;
    prod_r    <= mul_a * mul_b;
    mean_r    <= mean_nxt;
    stim_r    <= stim_nxt;
    rdy_r     <= rdy_nxt;
    was_cal_r <= was_cal_nxt;
    k_r       <= k_nxt;
    pre_r     <= pre_nxt;
    bit_r     <= bit_nxt;
    sidx_r    <= sidx_nxt;
    scnt_r    <= scnt_nxt;
    o_mean_r  <= o_mean_nxt;
    o_cal_r   <= o_cal_nxt;
    o_rdy_r   <= o_rdy_nxt;
    o_thr_r   <= o_thr_nxt;
    o_stim_r  <= o_stim_nxt;
    o_amp_r   <= o_amp_nxt;
    o_pw_r    <= o_pw_nxt;
    o_freq_r  <= o_freq_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      ptr_r       <= '0;
      wrap_r      <= 1'b0;
      cnt_r       <= '0;
      cal_r       <= 1'b1;
      thr_r       <= '0;
      rdv_r       <= 1'b0;
      frac_r      <= atst_pkg::FRAC_RESET;
      amp_r       <= '0;
      pw_r        <= '0;
      freq_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      ptr_r       <= ptr_nxt;
      wrap_r      <= wrap_nxt;
      cnt_r       <= cnt_nxt;
      cal_r       <= cal_nxt;
      thr_r       <= thr_nxt;
      rdv_r       <= rdv_nxt;
      frac_r      <= frac_nxt;
      amp_r       <= amp_nxt;
      pw_r        <= pw_nxt;
      freq_r      <= freq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[ptr_r] <= mag_r;
    end
    win_rd_r <= win_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cal_we) begin
      cal_mem[cnt_r[IW-1:0]] <= mean_r;
    end
    cal_rd_r <= cal_mem[sidx_r];
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_mean_amplitude  = o_mean_r;
  assign out_calibrating     = o_cal_r;
  assign out_threshold_ready = o_rdy_r;
  assign out_threshold_level = o_thr_r;
  assign out_stimulate       = o_stim_r;
  assign out_out_amplitude   = o_amp_r;
  assign out_out_pulse_width = o_pw_r;
  assign out_out_frequency   = o_freq_r;

  `ATST_ASSERT_IMP(a_stim_after_cal, clk, rst_n, out_valid && out_stimulate, !out_calibrating && (out_mean_amplitude > out_threshold_level))
  `ATST_ASSERT_IMP(a_ready_in_cal, clk, rst_n, out_valid && out_threshold_ready, out_calibrating)
  `ATST_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

/* bench/tb.sv */
module tb;

  localparam int unsigned DATA_W    = atst_pkg::DATA_W;
  localparam int unsigned CFG_IDX_W = atst_pkg::CFG_IDX_W;
  localparam int unsigned WIN_DEF   = atst_pkg::WIN_DEF;
  localparam int unsigned NINIT_DEF = atst_pkg::NINIT_DEF;

  localparam int unsigned LIMIT      = 400000;
  localparam int unsigned MAG_MAX    = 32768;
  localparam int unsigned N_PHASES   = 9;
  localparam int unsigned N_DIRECTED = 18;
  localparam int unsigned PRINT_CAP  = 200;

  typedef struct packed {
    logic [DATA_W-1:0] mean;
    logic              calibrating;
    logic              ready;
    logic [DATA_W-1:0] level;
    logic              stimulate;
    logic [DATA_W-1:0] amplitude;
    logic [DATA_W-1:0] pulse_width;
    logic [DATA_W-1:0] frequency;
  } trig_result_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] smp;
    logic                     typed;
    logic [DATA_W-1:0]        mean;
  } directed_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_filtered_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DATA_W-1:0]        out_mean_amplitude;
  logic                     out_calibrating;
  logic                     out_threshold_ready;
  logic [DATA_W-1:0]        out_threshold_level;
  logic                     out_stimulate;
  logic [DATA_W-1:0]        out_out_amplitude;
  logic [DATA_W-1:0]        out_out_pulse_width;
  logic [DATA_W-1:0]        out_out_frequency;

  // Expected results are typed in only for the first requests after reset.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'sh8000, 1'b1, 16'd512},
    '{16'sh7FFF, 1'b1, 16'd1023},
    '{16'shFFFF, 1'b1, 16'd1024},
    '{16'sh0000, 1'b1, 16'd1024},
    '{16'sh0001, 1'b1, 16'd1024},
    '{16'sh5555, 1'b0, 16'd0},
    '{16'shAAAA, 1'b0, 16'd0},
    '{16'sh4000, 1'b0, 16'd0},
    '{16'shC000, 1'b0, 16'd0},
    '{16'sh00FF, 1'b0, 16'd0},
    '{16'shFF00, 1'b0, 16'd0},
    '{16'sh8001, 1'b0, 16'd0},
    '{16'sh7FFF, 1'b0, 16'd0},
    '{16'sh8000, 1'b0, 16'd0},
    '{16'sh0F0F, 1'b0, 16'd0},
    '{16'shF0F0, 1'b0, 16'd0},
    '{16'sh2000, 1'b0, 16'd0},
    '{16'shE000, 1'b0, 16'd0}
  };

  int unsigned item_count [N_PHASES] = '{322, 340, 344, 55, 55, 55, 55, 55, 55};

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned errors = 0;
  int unsigned results_seen = 0;

  trig_result_t pending_triggers [$];

  int unsigned       mag_hist [WIN_DEF];
  int unsigned       hist_pos;
  int unsigned       mag_total;
  logic [DATA_W-1:0] calib_means [$];
  logic              calib_active;
  logic [DATA_W-1:0] thr_level;
  logic [DATA_W-1:0] frac_reg;
  logic [DATA_W-1:0] amp_reg;
  logic [DATA_W-1:0] pw_reg;
  logic [DATA_W-1:0] freq_reg;

  adaptive_threshold_stim_trigger i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_filtered_sample  (in_filtered_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mean_amplitude  (out_mean_amplitude),
    .out_calibrating     (out_calibrating),
    .out_threshold_ready (out_threshold_ready),
    .out_threshold_level (out_threshold_level),
    .out_stimulate       (out_stimulate),
    .out_out_amplitude   (out_out_amplitude),
    .out_out_pulse_width (out_out_pulse_width),
    .out_out_frequency   (out_out_frequency)
  );

  always #1 clk = ~clk;

  function automatic void reset_trigger_model();
    foreach (mag_hist[i]) mag_hist[i] = 0;
    hist_pos = 0;
    mag_total = 0;
    calib_means.delete();
    calib_active = 1'b1;
    thr_level = '0;
    frac_reg = atst_pkg::FRAC_RESET;
    amp_reg = '0;
    pw_reg = '0;
    freq_reg = '0;
  endfunction

  function automatic trig_result_t predict_trigger(input logic signed [DATA_W-1:0] smp);
    trig_result_t      r;
    int                mag;
    int unsigned       rank;
    logic [DATA_W-1:0] ranked [$];
    mag = (smp < 0) ? -int'(smp) : int'(smp);
    mag_total = mag_total - mag_hist[hist_pos] + unsigned'(mag);
    mag_hist[hist_pos] = unsigned'(mag);
    hist_pos = (hist_pos + 1) % WIN_DEF;
    r = '0;
    r.mean = DATA_W'(mag_total / WIN_DEF);
    r.calibrating = calib_active;
    if (calib_active) begin
      calib_means.push_back(r.mean);
      if (calib_means.size() == NINIT_DEF) begin
        rank = (NINIT_DEF * frac_reg) >> 16;
        if (rank > NINIT_DEF - 1) rank = NINIT_DEF - 1;
        ranked = calib_means;
        ranked.sort();
        thr_level = ranked[rank];
        calib_active = 1'b0;
        r.ready = 1'b1;
      end
    end else if (r.mean > thr_level) begin
      r.stimulate = 1'b1;
      r.amplitude = amp_reg;
      r.pulse_width = pw_reg;
      r.frequency = freq_reg;
    end
    r.level = thr_level;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sample_of_mag(input int unsigned mag,
                                                             input bit neg);
    logic [DATA_W-1:0] m;
    if (mag >= MAG_MAX) return 16'sh8000;
    m = mag[DATA_W-1:0];
    return neg ? (~m + 16'd1) : m;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("result %0d: %s is %0d, should be %0d", results_seen, what, got, want);
  endtask

  task automatic cfg_write(input atst_pkg::cfg_idx_t idx, input logic [DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      atst_pkg::CFG_FRAC: frac_reg = val;
      atst_pkg::CFG_AMP:  amp_reg = val;
      atst_pkg::CFG_PW:   pw_reg = val;
      atst_pkg::CFG_FREQ: freq_reg = val;
    endcase
    @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [DATA_W-1:0] smp, input logic typed,
                             input logic [DATA_W-1:0] typed_mean);
    trig_result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_filtered_sample <= smp;
    do @(posedge clk); while (in_stall);
    r = predict_trigger(smp);
    if (typed) begin
      r = '0;
      r.mean = typed_mean;
      r.calibrating = 1'b1;
    end
    pending_triggers.push_back(r);
    @(negedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    trig_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_triggers.size() == 0) begin
        report("request with nothing pending", 1, 0);
      end else begin
        want = pending_triggers.pop_front();
        if (out_mean_amplitude !== want.mean)
          report("mean_amplitude", out_mean_amplitude, want.mean);
        if (out_calibrating !== want.calibrating)
          report("calibrating", out_calibrating, want.calibrating);
        if (out_threshold_ready !== want.ready)
          report("threshold_ready", out_threshold_ready, want.ready);
        if (out_threshold_level !== want.level)
          report("threshold_level", out_threshold_level, want.level);
        if (out_stimulate !== want.stimulate)
          report("stimulate", out_stimulate, want.stimulate);
        if (out_out_amplitude !== want.amplitude)
          report("out_amplitude", out_out_amplitude, want.amplitude);
        if (out_out_pulse_width !== want.pulse_width)
          report("out_pulse_width", out_out_pulse_width, want.pulse_width);
        if (out_out_frequency !== want.frequency)
          report("out_frequency", out_out_frequency, want.frequency);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("adaptive_threshold_stim_trigger test failed");
    $finish;
  end

  initial begin
    logic signed [DATA_W-1:0] smp;
    logic [DATA_W-1:0]        frac;
    int unsigned              burst_left;
    int unsigned              burst_mag;
    int                       lvl;
    burst_left = 0;
    burst_mag = 0;
    reset_trigger_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 3)
        0: begin
          send_idle = 11;
          recv_idle = 84;
        end
        1: begin
          send_idle = 84;
          recv_idle = 11;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase

      // The fraction written before the calibration ends picks the threshold rank.
      frac = 16'($urandom_range(65535));
      if (ph == 2) begin
        case ($urandom_range(3))
          0: frac = 16'h0000;
          1: frac = 16'hFFFF;
          2: frac = atst_pkg::FRAC_RESET;
          default: ;
        endcase
      end
      cfg_write(atst_pkg::CFG_FRAC, frac);
      case (ph)
        3: begin
          cfg_write(atst_pkg::CFG_AMP, 16'h0000);
          cfg_write(atst_pkg::CFG_PW, 16'h0000);
          cfg_write(atst_pkg::CFG_FREQ, 16'h0000);
        end
        4: begin
          cfg_write(atst_pkg::CFG_AMP, 16'hFFFF);
          cfg_write(atst_pkg::CFG_PW, 16'hFFFF);
          cfg_write(atst_pkg::CFG_FREQ, 16'hFFFF);
        end
        default: begin
          cfg_write(atst_pkg::CFG_AMP, 16'($urandom_range(65535)));
          cfg_write(atst_pkg::CFG_PW, 16'($urandom_range(65535)));
          cfg_write(atst_pkg::CFG_FREQ, 16'($urandom_range(65535)));
        end
      endcase
      cfg_we <= 1'b0;

      if (ph == 0) begin
        foreach (directed_rows[i])
          send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].mean);
      end

      // A full window at the threshold must not stimulate; one larger sample must.
      if (ph == 3) begin
        for (int i = 0; i < WIN_DEF; i++)
          send_sample(sample_of_mag(thr_level, 1'($urandom_range(1))), 1'b0, '0);
        send_sample(sample_of_mag(thr_level + WIN_DEF, 1'($urandom_range(1))), 1'b0, '0);
        burst_left = 0;
      end

      for (int i = 0; i < item_count[ph]; i++) begin
        if ($urandom_range(99) < (calib_active ? 15 : 5)) begin
          smp = 16'($urandom_range(65535));
        end else begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(80, 1);
            if (calib_active) begin
              case ($urandom_range(7))
                0: burst_mag = 0;
                1: burst_mag = MAG_MAX;
                default: burst_mag = $urandom_range(MAG_MAX);
              endcase
            end else begin
              lvl = int'(thr_level) + int'($urandom_range(256)) - 128;
              if (lvl < 0) lvl = 0;
              if (lvl > int'(MAG_MAX)) lvl = int'(MAG_MAX);
              burst_mag = unsigned'(lvl);
            end
          end
          burst_left--;
          smp = sample_of_mag(burst_mag, 1'($urandom_range(1)));
        end
        send_sample(smp, 1'b0, '0);
      end

      in_valid <= 1'b0;
      while (pending_triggers.size() != 0) @(negedge clk);
      repeat (20) @(negedge clk);
    end

    if (errors == 0) begin
      $display("adaptive_threshold_stim_trigger test passed");
    end else begin
      $display("adaptive_threshold_stim_trigger test failed");
    end
    $finish;
  end

endmodule
